// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/sdfg_pkg.sv
// Shared types and constants of the SDF grid trilinear sampler.
// No dependencies.
package sdfg_pkg;

    localparam int MAX_GRID_DEF    = 64;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QDEPTH          = 16;
    localparam int IN_TDATA_W      = 152;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int GRID_SIZE_W     = 7;
    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
    localparam logic [30:0]            INV_SPACING_RST = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE,
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_INV_SPACING,
        CFG_LEVEL_VALUE,
        CFG_INSIDE_NEGATE
    } cfg_reg_t;

    // Control that travels down the pipeline with each request.
    typedef struct packed {
        logic valid;
        logic query;
    } pipe_ctl_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic        [30:0] inv_spacing;
    } geo_cfg_t;

    typedef struct packed {
        logic signed [31:0] distance;
        logic               saturated;
    } result_t;

endpackage

// File: design/sdfg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sdfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/sdfg_addr.sv
// Coordinate mapping and corner address generation for the sampler.
// Depends on sdfg_pkg.
module sdfg_addr #(
    parameter int MAX_GRID  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sdfg_pkg::pipe_ctl_t                   in_ctl,
    input  logic [17:0]                           sample_index,
    input  logic [31:0]                           sample_value,
    input  logic signed [31:0]                    point_x,
    input  logic signed [31:0]                    point_y,
    input  logic signed [31:0]                    point_z,
    input  sdfg_pkg::geo_cfg_t                    geo,
    input  logic [$clog2(MAX_GRID):0]             grid_n,
    input  logic [2*$clog2(MAX_GRID)+1:0]         grid_nn,
    output sdfg_pkg::pipe_ctl_t                   out_ctl,
    output logic                                  mem_we,
    output logic [$clog2(MAX_GRID**3)-1:0]        mem_waddr,
    output logic [31:0]                           mem_wdata,
    output logic [$clog2(MAX_GRID**3)-1:0]        mem_raddr [8],
    output logic [FRAC_BITS-1:0]                  frac [3]
);
    import sdfg_pkg::*;

    localparam int IW = $clog2(MAX_GRID);
    localparam int NW = IW + 1;
    localparam int AW = $clog2(MAX_GRID**3);
    localparam int W0 = 64 - 2*FRAC_BITS;
    localparam int SW = 3*NW + 2;
    localparam longint CELLS = longint'(MAX_GRID) * MAX_GRID * MAX_GRID;

    function automatic logic [IW-1:0] clamp_idx(input logic signed [W0:0] v,
                                                 input logic [NW-1:0] nm1);
        logic [IW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(W0+1-NW){1'b0}}, nm1})) begin
            r = nm1[IW-1:0];
        end else begin
            r = v[IW-1:0];
        end
        return r;
    endfunction

    // Stage 1: offsets from the origin.
    pipe_ctl_t          ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic signed [32:0] d_reg [3];
    logic signed [32:0] d_next [3];
    logic [17:0]        idx1_reg, idx2_reg;
    logic [31:0]        val1_reg, val2_reg, val3_reg, val4_reg;
    logic signed [63:0] prod_reg [3];
    logic [IW-1:0]      lo_reg [3];
    logic [IW-1:0]      hi_reg [3];
    logic [IW-1:0]      lo_next [3];
    logic [IW-1:0]      hi_next [3];
    logic [FRAC_BITS-1:0] f3_reg [3];
    logic [FRAC_BITS-1:0] f4_reg [3];
    logic               ok3_reg, we4_reg;
    logic [AW-1:0]      waddr3_reg, waddr4_reg;
    logic [AW-1:0]      raddr_reg [8];
    logic [AW-1:0]      raddr_next [8];
    logic [NW-1:0]      nm1;

    assign nm1 = grid_n - NW'(1);

    always_comb begin
        d_next[0] = {point_x[31], point_x} - {geo.origin_x[31], geo.origin_x};
        d_next[1] = {point_y[31], point_y} - {geo.origin_y[31], geo.origin_y};
        d_next[2] = {point_z[31], point_z} - {geo.origin_z[31], geo.origin_z};
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo_next[a] = clamp_idx({prod_reg[a][63], prod_reg[a][63:2*FRAC_BITS]}, nm1);
            hi_next[a] = clamp_idx({prod_reg[a][63], prod_reg[a][63:2*FRAC_BITS]}
                                   + (W0+1)'(1), nm1);
        end
    end

    // Corner c takes bit 0 for x, bit 1 for y, bit 2 for z.
    always_comb begin
        logic [IW-1:0] ci, cj, ck;
        logic [SW-1:0] sum;
        for (int c = 0; c < 8; c++) begin
            ci = c[0] ? hi_reg[0] : lo_reg[0];
            cj = c[1] ? hi_reg[1] : lo_reg[1];
            ck = c[2] ? hi_reg[2] : lo_reg[2];
            sum = SW'(ci) + SW'(cj) * SW'(grid_n) + SW'(ck) * SW'(grid_nn);
            raddr_next[c] = sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            we4_reg  <= 1'b0;
        end else begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            we4_reg  <= ctl3_reg.valid && !ctl3_reg.query && ok3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            d_reg[a]    <= d_next[a];
            prod_reg[a] <= d_reg[a] * $signed({1'b0, geo.inv_spacing});
            lo_reg[a]   <= lo_next[a];
            hi_reg[a]   <= hi_next[a];
            f3_reg[a]   <= prod_reg[a][2*FRAC_BITS-1:FRAC_BITS];
            f4_reg[a]   <= f3_reg[a];
        end
        idx1_reg   <= sample_index;
        val1_reg   <= sample_value;
        idx2_reg   <= idx1_reg;
        val2_reg   <= val1_reg;
        ok3_reg    <= 64'(idx2_reg) < 64'(CELLS);
        waddr3_reg <= AW'(idx2_reg);
        val3_reg   <= val2_reg;
        waddr4_reg <= waddr3_reg;
        val4_reg   <= val3_reg;
        for (int c = 0; c < 8; c++) begin
            raddr_reg[c] <= raddr_next[c];
        end
    end

    assign out_ctl   = ctl4_reg;
    assign mem_we    = we4_reg;
    assign mem_waddr = waddr4_reg;
    assign mem_wdata = val4_reg;
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            mem_raddr[c] = raddr_reg[c];
        end
        for (int a = 0; a < 3; a++) begin
            frac[a] = f4_reg[a];
        end
    end
endmodule

// File: design/sdfg_blend.sv
// Trilinear blend of the eight corner samples, level offset and saturation.
// Depends on sdfg_pkg.
module sdfg_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdfg_pkg::pipe_ctl_t  in_ctl,
    input  logic [FRAC_BITS-1:0] frac [3],
    input  logic [31:0]          corner [8],
    input  logic signed [31:0]   iso_level,
    input  logic                 inside_negate,
    output logic                 out_valid,
    output sdfg_pkg::result_t    out_result
);
    import sdfg_pkg::*;

    localparam int LW = 35 + FRAC_BITS;

    // Rounded blend: (a*(1-f) + b*f + half) >>> FRAC_BITS.
    function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS:0]    wf;
        logic signed [LW-1:0]  pa, pb, s;
        wf = (FRAC_BITS+1)'(1) << FRAC_BITS;
        wf = wf - {1'b0, f};
        pa = a * $signed({1'b0, wf});
        pb = b * $signed({1'b0, f});
        s  = pa + pb + (LW'(1) <<< (FRAC_BITS-1));
        return s[FRAC_BITS+31:FRAC_BITS];
    endfunction

    pipe_ctl_t            ctl0_reg, ctl1_reg, ctl2_reg, ctl3_reg;
    logic                 valid4_reg;
    logic [FRAC_BITS-1:0] f0_reg [3];
    logic [FRAC_BITS-1:0] fy1_reg, fz1_reg, fz2_reg;
    logic signed [31:0]   cx_reg [4];
    logic signed [31:0]   cy_reg [2];
    logic signed [31:0]   v_reg;
    result_t              res_reg, res_next;
    logic signed [33:0]   r;

    always_comb begin
        r = {{2{v_reg[31]}}, v_reg} - {{2{iso_level[31]}}, iso_level};
        if (inside_negate) begin
            r = -r;
        end
        res_next.saturated = (r[33:31] != 3'b000) && (r[33:31] != 3'b111);
        if (!res_next.saturated) begin
            res_next.distance = r[31:0];
        end else if (r[33]) begin
            res_next.distance = 32'sh8000_0000;
        end else begin
            res_next.distance = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg   <= '0;
            ctl1_reg   <= '0;
            ctl2_reg   <= '0;
            ctl3_reg   <= '0;
            valid4_reg <= 1'b0;
        end else begin
            ctl0_reg   <= in_ctl;
            ctl1_reg   <= ctl0_reg;
            ctl2_reg   <= ctl1_reg;
            ctl3_reg   <= ctl2_reg;
            valid4_reg <= ctl3_reg.valid && ctl3_reg.query;
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            f0_reg[a] <= frac[a];
        end
        for (int m = 0; m < 4; m++) begin
            cx_reg[m] <= lerp(corner[2*m], corner[2*m+1], f0_reg[0]);
        end
        fy1_reg   <= f0_reg[1];
        fz1_reg   <= f0_reg[2];
        cy_reg[0] <= lerp(cx_reg[0], cx_reg[1], fy1_reg);
        cy_reg[1] <= lerp(cx_reg[2], cx_reg[3], fy1_reg);
        fz2_reg   <= fz1_reg;
        v_reg     <= lerp(cy_reg[0], cy_reg[1], fz2_reg);
        res_reg   <= res_next;
    end

    assign out_valid  = valid4_reg;
    assign out_result = res_reg;
endmodule

// File: design/sdfg_fifo.sv
// Small result queue that decouples the pipeline from the output handshake.
// No dependencies.
module sdfg_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  logic [WIDTH-1:0]         din,
    input  logic                     pop,
    output logic                     valid,
    output logic [WIDTH-1:0]         dout,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH-1)) ? '0 : wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH-1)) ? '0 : rptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

    assign valid = count_reg != '0;
    assign dout  = mem_reg[rptr_reg];
    assign level = count_reg;
endmodule

// File: design/sdf_grid_trilinear_sampler_top.sv
// Top level of the SDF grid trilinear sampler.
// Depends on sdfg_pkg, sdfg_ram, sdfg_addr, sdfg_blend, sdfg_fifo and assert_macros.svh.
//
// The sampler takes one request per clock cycle while s_tready is high, loads and
// queries mixed in any order. A load (tuser 0) writes one Q16.16 sample at its flat
// index i + j*N + k*N*N and returns nothing; an index beyond the grid memory is
// dropped. A query (tuser 1) maps its point to grid coordinates, blends the eight
// surrounding samples trilinearly, subtracts the iso level, optionally negates, and
// returns the saturated distance with a saturation flag in m_tuser. The one-per-cycle
// rate comes from the grid memory: it is held in eight identical copies, each written
// by every load that is kept, so the eight corners of a query are read in a single
// cycle at their own addresses. Up to sixteen query results may be outstanding;
// beyond that s_tready drops until the downstream side takes results. Grid samples
// are undefined until loaded, and there is no clearing pass after reset.
// Configuration writes must be made while no request is in flight.
`include "assert_macros.svh"

module sdf_grid_trilinear_sampler_top #(
    parameter int MAX_GRID  = sdfg_pkg::MAX_GRID_DEF,
    parameter int FRAC_BITS = sdfg_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input requests.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sample_index[17:0], sample_value[49:18], point_x[81:50], point_y[113:82],
    // point_z[145:114], zero fill[151:146]
    input  logic [sdfg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // mode: 0 load, 1 query
    input  logic                             s_tuser,
    // Results.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // distance[31:0]
    output logic [31:0]                      m_tdata,
    // saturated
    output logic                             m_tuser,
    // Configuration writes.
    input  logic                             cfg_we,
    input  logic [sdfg_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sdfg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import sdfg_pkg::*;

    localparam int IW  = $clog2(MAX_GRID);
    localparam int NW  = IW + 1;
    localparam int AW  = $clog2(MAX_GRID**3);
    localparam int CW  = $clog2(QDEPTH+1);
    localparam int LAT = 9;

    // Configuration registers.
    logic [GRID_SIZE_W-1:0] grid_size_reg;
    geo_cfg_t               geo_reg;
    logic signed [31:0]     level_reg;
    logic                   negate_reg;
    logic [NW-1:0]          grid_n_reg, grid_n_next;
    logic [2*NW-1:0]        grid_nn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg       <= GRID_SIZE_RST;
            geo_reg.origin_x    <= '0;
            geo_reg.origin_y    <= '0;
            geo_reg.origin_z    <= '0;
            geo_reg.inv_spacing <= INV_SPACING_RST;
            level_reg           <= '0;
            negate_reg          <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_GRID_SIZE:     grid_size_reg       <= cfg_wdata[GRID_SIZE_W-1:0];
                CFG_ORIGIN_X:      geo_reg.origin_x    <= cfg_wdata;
                CFG_ORIGIN_Y:      geo_reg.origin_y    <= cfg_wdata;
                CFG_ORIGIN_Z:      geo_reg.origin_z    <= cfg_wdata;
                CFG_INV_SPACING:   geo_reg.inv_spacing <= cfg_wdata[30:0];
                CFG_LEVEL_VALUE:   level_reg           <= cfg_wdata;
                CFG_INSIDE_NEGATE: negate_reg          <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The grid size in use is clamped to [2, MAX_GRID]; N and N*N are kept registered.
    always_comb begin
        if (grid_size_reg < GRID_SIZE_W'(2)) begin
            grid_n_next = NW'(2);
        end else if (32'(grid_size_reg) > MAX_GRID) begin
            grid_n_next = NW'(MAX_GRID);
        end else begin
            grid_n_next = NW'(grid_size_reg);
        end
    end

    always_ff @(posedge aclk) begin
        grid_n_reg  <= grid_n_next;
        grid_nn_reg <= grid_n_reg * grid_n_reg;
    end

    // Outstanding query count, bounded by the result queue depth.
    logic          s_accept, q_accept, m_accept;
    logic [CW-1:0] inflight_reg;
    logic [CW-1:0] q_level;

    assign s_tready = inflight_reg != CW'(QDEPTH);
    assign s_accept = s_tvalid && s_tready;
    assign q_accept = s_accept && s_tuser;
    assign m_accept = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + CW'(q_accept) - CW'(m_accept);
        end
    end

    // Address generation.
    pipe_ctl_t            in_ctl, addr_ctl;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [31:0]          mem_wdata;
    logic [AW-1:0]        mem_raddr [8];
    logic [31:0]          corner [8];
    logic [FRAC_BITS-1:0] frac [3];

    assign in_ctl.valid = s_accept;
    assign in_ctl.query = s_tuser;

    sdfg_addr #(
        .MAX_GRID  (MAX_GRID),
        .FRAC_BITS (FRAC_BITS)
    ) u_addr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_ctl       (in_ctl),
        .sample_index (s_tdata[17:0]),
        .sample_value (s_tdata[49:18]),
        .point_x      (s_tdata[81:50]),
        .point_y      (s_tdata[113:82]),
        .point_z      (s_tdata[145:114]),
        .geo          (geo_reg),
        .grid_n       (grid_n_reg),
        .grid_nn      (grid_nn_reg),
        .out_ctl      (addr_ctl),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .frac         (frac)
    );

    // Eight copies of the grid, one per corner. Loads and reads are issued from the
    // same stage in request order, so a query always sees every earlier load.
    for (genvar c = 0; c < 8; c++) begin : g_copy
        sdfg_ram #(
            .WIDTH (32),
            .DEPTH (MAX_GRID**3)
        ) u_ram (
            .clk   (aclk),
            .we    (mem_we),
            .waddr (mem_waddr),
            .wdata (mem_wdata),
            .raddr (mem_raddr[c]),
            .rdata (corner[c])
        );
    end

    // Blend and result.
    logic    blend_valid;
    result_t blend_result, q_dout;
    logic    q_valid;

    sdfg_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_ctl        (addr_ctl),
        .frac          (frac),
        .corner        (corner),
        .iso_level     (level_reg),
        .inside_negate (negate_reg),
        .out_valid     (blend_valid),
        .out_result    (blend_result)
    );

    sdfg_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QDEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (blend_valid),
        .din     (blend_result),
        .pop     (m_accept),
        .valid   (q_valid),
        .dout    (q_dout),
        .level   (q_level)
    );

    assign m_tvalid = q_valid;
    assign m_tdata  = q_dout.distance;
    assign m_tuser  = q_dout.saturated;

    // Checks.
    `ASSERT_CLK(a_no_push_full, aclk, aresetn, blend_valid |-> q_level != CW'(QDEPTH),
                "result pushed into a full queue")
    `ASSERT_CLK(a_credit_cover, aclk, aresetn, inflight_reg >= q_level,
                "queued results exceed outstanding queries")
    `ASSERT_CLK(a_result_origin, aclk, aresetn, blend_valid |-> $past(q_accept, LAT),
                "result without a query accepted at the pipeline latency")
endmodule

// File: tb/sdfg_result_checker.sv
// Result checker for the SDF grid trilinear sampler: keeps its own grid copy and
// configuration, predicts each query's distance and compares results. Depends on sdfg_pkg.
module sdfg_result_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    output int           fail_count,
    output int           pending
);
    import sdfg_pkg::*;

    localparam int FB = 16;
    localparam longint CELLS = 64 * 64 * 64;

    typedef struct packed {
        logic [31:0] distance;
        logic        saturated;
    } dist_t;

    logic [31:0] grid_copy [longint];
    logic [6:0]  n_cfg;
    logic signed [31:0] org [3];
    logic [30:0] inv_sp;
    logic signed [31:0] level;
    logic        negate;
    dist_t       dist_queue [$];

    function automatic longint lerp_q(longint a, longint b, longint f);
        return (a * ((64'sd1 <<< FB) - f) + b * f + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic longint grid_at(longint i, longint j, longint k, longint n);
        longint idx;
        idx = i + j * n + k * n * n;
        if (grid_copy.exists(idx)) return longint'(signed'(grid_copy[idx]));
        return 0;
    endfunction

    function automatic dist_t predict_distance(logic [151:0] d);
        longint n, prod, base, r;
        longint lo [3];
        longint hi [3];
        longint fr [3];
        longint c00, c01, c10, c11, c0, c1;
        logic signed [31:0] p;
        dist_t res;
        n = n_cfg < 2 ? 2 : (n_cfg > 64 ? 64 : n_cfg);
        for (int a = 0; a < 3; a++) begin
            p = d[50 + 32*a +: 32];
            prod = (longint'(p) - longint'(org[a])) * longint'({33'd0, inv_sp});
            base = prod >>> (2 * FB);
            fr[a] = (prod >>> FB) & ((64'sd1 <<< FB) - 1);
            lo[a] = base < 0 ? 0 : (base > n - 1 ? n - 1 : base);
            hi[a] = base + 1 < 0 ? 0 : (base + 1 > n - 1 ? n - 1 : base + 1);
        end
        c00 = lerp_q(grid_at(lo[0], lo[1], lo[2], n), grid_at(hi[0], lo[1], lo[2], n), fr[0]);
        c01 = lerp_q(grid_at(lo[0], lo[1], hi[2], n), grid_at(hi[0], lo[1], hi[2], n), fr[0]);
        c10 = lerp_q(grid_at(lo[0], hi[1], lo[2], n), grid_at(hi[0], hi[1], lo[2], n), fr[0]);
        c11 = lerp_q(grid_at(lo[0], hi[1], hi[2], n), grid_at(hi[0], hi[1], hi[2], n), fr[0]);
        c0 = lerp_q(c00, c10, fr[1]);
        c1 = lerp_q(c01, c11, fr[1]);
        r = lerp_q(c0, c1, fr[2]) - longint'(level);
        if (negate) r = -r;
        res.saturated = 1'b0;
        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            res.saturated = 1'b1;
        end
        if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            res.saturated = 1'b1;
        end
        res.distance = r[31:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        dist_t want;
        longint idx;
        if (!aresetn) begin
            n_cfg <= GRID_SIZE_RST;
            org[0] <= '0;
            org[1] <= '0;
            org[2] <= '0;
            inv_sp <= INV_SPACING_RST;
            level <= '0;
            negate <= 1'b0;
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    CFG_GRID_SIZE:     n_cfg <= cfg_wdata[6:0];
                    CFG_ORIGIN_X:      org[0] <= cfg_wdata;
                    CFG_ORIGIN_Y:      org[1] <= cfg_wdata;
                    CFG_ORIGIN_Z:      org[2] <= cfg_wdata;
                    CFG_INV_SPACING:   inv_sp <= cfg_wdata[30:0];
                    CFG_LEVEL_VALUE:   level <= cfg_wdata;
                    CFG_INSIDE_NEGATE: negate <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (!s_tuser) begin
                    idx = s_tdata[17:0];
                    if (idx < CELLS) grid_copy[idx] = s_tdata[49:18];
                end else begin
                    dist_queue.push_back(predict_distance(s_tdata));
                end
            end
            if (m_tvalid && m_tready) begin
                if (dist_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result: distance %h saturated %b",
                                 m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = dist_queue.pop_front();
                    if (want.distance !== m_tdata || want.saturated !== m_tuser) begin
                        if (fail_count < 10)
                            $display("Mismatch: expected %h/%b, got %h/%b",
                                     want.distance, want.saturated, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= dist_queue.size();
        end
    end
endmodule

// File: tb/tb_sdf_grid_trilinear_sampler_top.sv
// Testbench top for the SDF grid trilinear sampler: drives loads, queries and
// configuration, and gives the verdict. Depends on sdfg_pkg and sdfg_result_checker.
module tb_sdf_grid_trilinear_sampler_top;
    import sdfg_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    int           fail_count;
    int           pending;
    longint       cycles = 0;
    bit           calm;     // no idling on either side in the last part of the run
    int           grid_n;   // effective grid size now in use
    int           fill_n;   // per-axis extent of the loaded cube at the grid origin

    sdf_grid_trilinear_sampler_top dut (.*);

    sdfg_result_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The cycle counter ends a run that hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver stalls in random bursts, then runs free for a while.
    initial begin
        int burst;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (calm || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
            end else begin
                burst = $urandom_range(1, 16);
                m_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Sends one request and holds it until it is accepted. A random gap may come first.
    task automatic send_request(input logic mode, input logic [151:0] data);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_sample(input int idx, input logic [31:0] value);
        send_request(1'b0, {102'd0, value, idx[17:0]});
    endtask

    task automatic query_point(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz);
        send_request(1'b1, {6'd0, pz, py, px, 50'd0});
    endtask

    // Random sample: moderate half the time, otherwise fully random or at the extremes of the range.
    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    // Fills the fill_n^3 cube at the origin of the grid now in use. Queries stay inside
    // that cube, so no query reads an unwritten entry.
    task automatic fill_grid();
        for (int k = 0; k < fill_n; k++)
            for (int j = 0; j < fill_n; j++)
                for (int i = 0; i < fill_n; i++)
                    load_sample(i + j * grid_n + k * grid_n * grid_n, random_sample());
    endtask

    // Waits until every result is back, then lets the pipeline drain fully.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Points are drawn as offsets from the current origin, with some just below the
    // origin, outside the grid, and some fully random. Fully random points are
    // only drawn while the whole grid is loaded.
    function automatic logic [31:0] random_coord(input logic [31:0] origin);
        case ($urandom_range(0, 7))
            0: return (fill_n == grid_n) ? $urandom() : origin;
            1: return origin + $urandom_range(0, 32'h0000_FFFF) - 32'h0004_0000;
            default: return origin + $urandom_range(0, fill_n * 32'h0001_0000);
        endcase
    endfunction

    // One configuration phase: drain, program the registers, load the grid cube, issue queries and loads.
    task automatic run_phase(input logic [6:0] size_reg, input logic [31:0] ox,
                             input logic [31:0] oy, input logic [31:0] oz,
                             input logic [30:0] inv, input logic [31:0] lvl,
                             input logic neg, input int n_queries);
        drain();
        write_reg(CFG_GRID_SIZE, {25'd0, size_reg});
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_SPACING, {1'b0, inv});
        write_reg(CFG_LEVEL_VALUE, lvl);
        write_reg(CFG_INSIDE_NEGATE, {31'd0, neg});
        grid_n = size_reg < 2 ? 2 : (size_reg > 64 ? 64 : size_reg);
        // Large grids get only a small cube loaded; that phase keeps a small spacing
        // reciprocal so its points never reach past the cube.
        fill_n = grid_n > 6 ? 6 : grid_n;
        fill_grid();
        for (int q = 0; q < n_queries; q++) begin
            if ($urandom_range(0, 9) == 0)
                load_sample($urandom_range(0, grid_n ** 3 - 1), random_sample());
            else if ($urandom_range(0, 19) == 0)
                // These loads hit index 262143 or, cut to 18 bits, index 0; the block keeps both.
                load_sample($urandom_range(64 * 64 * 64, 262143), $urandom());
            else
                query_point(random_coord(ox), random_coord(oy), random_coord(oz));
        end
    endtask

    initial begin
        calm      = 1'b0;
        grid_n    = 64;
        fill_n    = 64;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the smallest grid: corners, extreme points, extreme samples.
        run_phase(7'd2, 32'h0, 32'h0, 32'h0, 31'd65536, 32'h0, 1'b0, 0);
        query_point(32'h0, 32'h0, 32'h0);
        query_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        query_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        query_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_0001);
        load_sample(0, 32'h7FFF_FFFF);
        load_sample(262143, 32'hFFFF_FFFF);
        load_sample(1, 32'h8000_0000);
        query_point(32'h0000_4000, 32'h0, 32'h0);
        // The sender holds off here until every result has arrived.
        drain();

        // Zero spacing reciprocal, negation and saturation by the level value.
        run_phase(7'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 31'd0,
                  32'h7FFF_FFFF, 1'b1, 60);
        run_phase(7'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF,
                  32'h8000_0000, 1'b0, 200);
        run_phase(7'd127, 32'hFFF0_0000, 32'h0010_0000, 32'h0, 31'd13107,
                  $urandom(), 1'b1, 150);
        run_phase(7'd5, $urandom(), $urandom(), $urandom(), 31'd32768, 32'h0, 1'b0, 250);
        run_phase(7'd1, 32'h0, 32'h0, 32'h0, 31'd196608, 32'h8000_0000, 1'b1, 300);
        calm = 1'b1;
        run_phase(7'd4, 32'h0002_0000, 32'hFFFE_0000, 32'h0, 31'd65536, 32'h0, 1'b0, 300);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
